// ===== sv/block_bitmap_allocator_unit_macros.svh =====
// Assertion macros for the block bitmap allocator.
// Included by block_bitmap_allocator_unit; expects clk and rst in scope.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BBA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Shared constants, enumerations and width helpers for the block bitmap allocator.
// No dependencies; imported by bba_byte_scan and block_bitmap_allocator_unit.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 4096;
  localparam int unsigned BLOCK_BYTES_DEF = 256;

  localparam int unsigned BLOCK_W    = 12;
  localparam int unsigned LEN_W      = 21;
  localparam int unsigned LEN_SUM_W  = LEN_W + 1;
  localparam int unsigned RECIP_W    = LEN_SUM_W + 2;
  localparam int unsigned USED_W     = 13;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [APB_ADDR_W-3:0] REG_WRAP_ENABLE = '0;

  typedef enum logic [1:0] {
    ACT_ALLOC,
    ACT_FREE,
    ACT_MARK,
    ACT_EXTEND
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_RANGE,
    ST_NOTFREE
  } status_t;

  typedef enum logic [1:0] {
    PM_CHECK,
    PM_SET,
    PM_CLEAR
  } pass_mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_LEN,
    S_DECODE,
    S_SCAN,
    S_PASS,
    S_DONE
  } state_t;

  function automatic int unsigned map_addr_w(input int unsigned num_blocks);
    return $clog2((num_blocks + 7) / 8);
  endfunction

  function automatic int unsigned pos_w(input int unsigned num_blocks);
    return map_addr_w(num_blocks) + 4;
  endfunction

  function automatic int unsigned count_w(input int unsigned num_blocks);
    return $clog2(num_blocks + 1);
  endfunction

endpackage

// ===== sv/bba_byte_scan.sv =====
// One step of the free-run search: walks the eight blocks of one map byte.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_byte_scan import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic [7:0]                       map_byte,
  input  logic [pos_w(NUM_BLOCKS)-1:0]     base,
  input  logic [2:0]                       first_bit,
  input  logic [count_w(NUM_BLOCKS)-1:0]   run_len,
  input  logic [count_w(NUM_BLOCKS)-1:0]   cnt_in,
  input  logic [pos_w(NUM_BLOCKS)-1:0]     start_in,
  output logic                             hit,
  output logic [pos_w(NUM_BLOCKS)-1:0]     hit_start,
  output logic [count_w(NUM_BLOCKS)-1:0]   cnt_out,
  output logic [pos_w(NUM_BLOCKS)-1:0]     start_out
);

  localparam int unsigned PW = pos_w(NUM_BLOCKS);
  localparam int unsigned CW = count_w(NUM_BLOCKS);
  localparam logic [PW-1:0] NUM_POS = PW'(NUM_BLOCKS);

  always_comb begin
    logic [PW-1:0] pos;
    logic [CW-1:0] cnt;
    logic [PW-1:0] st;
    pos       = base;
    cnt       = cnt_in;
    st        = start_in;
    hit       = 1'b0;
    hit_start = start_in;
    if (run_len == '0) begin
      // A zero-length request fits anywhere that is not inside a full byte.
      hit       = (map_byte != FULL_BYTE);
      hit_start = {base[PW-1:3], first_bit};
    end else begin
      for (int j = 0; j < 8; j++) begin
        pos = {base[PW-1:3], 3'(j)};
        if (!hit && (3'(j) >= first_bit) && (pos < NUM_POS)) begin
          if (map_byte[j]) begin
            cnt = '0;
          end else begin
            if (cnt == '0) begin
              st = pos;
            end
            cnt = cnt + CW'(1);
            if (cnt == run_len) begin
              hit       = 1'b1;
              hit_start = st;
            end
          end
        end
      end
    end
    cnt_out   = cnt;
    start_out = st;
  end

endmodule

// ===== sv/block_bitmap_allocator_unit.sv =====
// Block bitmap allocator: one bit per block in a synchronous map memory, next-fit search.
// Depends on bba_pkg, bba_byte_scan and block_bitmap_allocator_unit_macros.svh.
// A request passes S_MUL, S_LEN and S_DECODE, then reads map bytes; an allocation reads bytes from the hint
// until a run fits (up to twice the map when it wraps), then each byte the run covers.
// One request at a time; the next is taken the cycle after the result is registered.
// After reset the map is cleared one byte per cycle.
`timescale 1ns / 1ps

`include "block_bitmap_allocator_unit_macros.svh"

module block_bitmap_allocator_unit import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            action,
  input  logic [BLOCK_W-1:0]    start_block,
  input  logic [LEN_W-1:0]      length_bytes,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [BLOCK_W-1:0]    result_block,
  output logic [1:0]            status,
  output logic [USED_W-1:0]     used_blocks
);

  localparam int unsigned MAP_BYTES = (NUM_BLOCKS + 7) / 8;
  localparam int unsigned AW        = map_addr_w(NUM_BLOCKS);
  localparam int unsigned PW        = pos_w(NUM_BLOCKS);
  localparam int unsigned CW        = count_w(NUM_BLOCKS);
  localparam int unsigned MAX_RUN   = ((1 << LEN_W) - 1 + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int unsigned NW        = $clog2(MAX_RUN + 1);
  localparam int unsigned XW_BASE   = (PW > NW) ? PW : NW;
  localparam int unsigned XW        = ((XW_BASE > BLOCK_W) ? XW_BASE : BLOCK_W) + 1;
  localparam int unsigned DIV_SHIFT = LEN_SUM_W + $clog2(BLOCK_BYTES);
  localparam int unsigned PRODW     = LEN_SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << DIV_SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_WIDE[RECIP_W-1:0];
  localparam logic [XW-1:0]      NUM_X   = XW'(NUM_BLOCKS);
  localparam logic [AW-1:0]      LAST_BYTE = AW'(MAP_BYTES - 1);

  state_t           state, state_next;
  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic             wrap_enable;
  action_t          act, act_next;
  logic [BLOCK_W-1:0] start_q, start_q_next;
  logic [LEN_W-1:0] len_q, len_q_next;
  logic [PRODW-1:0] prod, prod_next;
  logic [NW-1:0]    nblk, nblk_next;
  logic [PW-1:0]    free_hint, free_hint_next;
  logic [CW-1:0]    used_count, used_count_next;
  logic [AW-1:0]    scan_addr, scan_addr_next;
  logic [2:0]       scan_off, scan_off_next;
  logic [CW-1:0]    scan_cnt, scan_cnt_next;
  logic [PW-1:0]    scan_start, scan_start_next;
  logic             wrapped, wrapped_next;
  pass_mode_t       pass_mode, pass_mode_next;
  logic [AW-1:0]    pass_addr, pass_addr_next;
  logic [PW-1:0]    pass_first, pass_first_next;
  logic [PW-1:0]    pass_last, pass_last_next;
  logic [BLOCK_W-1:0] res_block, res_block_next;
  status_t          res_status, res_status_next;
  logic             res_load;

  logic [7:0]       map_mem [MAP_BYTES];
  logic [7:0]       map_rdata;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  logic [LEN_SUM_W-1:0] len_sum;
  logic [XW-1:0]    nblk_x, start_x, run_end_x, hit_end_x;
  logic             in_range, too_long, scan_last, pass_done;
  logic [CW-1:0]    run_len;
  logic             sc_hit;
  logic [PW-1:0]    sc_hit_start, sc_start;
  logic [CW-1:0]    sc_cnt;
  logic [2:0]       mask_lo, mask_hi;
  logic [7:0]       pass_mask;
  logic [3:0]       set_flips, clr_flips;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_WRAP_ENABLE) ?
                     APB_DATA_W'(wrap_enable) : '0;
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable <= 1'b1;
    end else if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_WRAP_ENABLE)) begin
      wrap_enable <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      map_rdata <= map_mem[mem_raddr];
    end
  end

  assign len_sum   = LEN_SUM_W'(len_q) + LEN_SUM_W'(BLOCK_BYTES - 1);
  assign nblk_x    = XW'(nblk);
  assign start_x   = XW'(start_q);
  assign run_end_x = start_x + nblk_x;
  assign in_range  = (start_x < NUM_X) && (run_end_x <= NUM_X);
  assign too_long  = (nblk_x > NUM_X);
  assign run_len   = nblk_x[CW-1:0];
  assign hit_end_x = XW'(sc_hit_start) + nblk_x;
  assign scan_last = (scan_addr == LAST_BYTE);
  assign pass_done = (pass_addr == pass_last[3 +: AW]);

  bba_byte_scan #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_scan (
    .map_byte (map_rdata),
    .base     (PW'({scan_addr, 3'b000})),
    .first_bit(scan_off),
    .run_len  (run_len),
    .cnt_in   (scan_cnt),
    .start_in (scan_start),
    .hit      (sc_hit),
    .hit_start(sc_hit_start),
    .cnt_out  (sc_cnt),
    .start_out(sc_start)
  );

  always_comb begin
    mask_lo = (pass_addr == pass_first[3 +: AW]) ? pass_first[2:0] : 3'd0;
    mask_hi = pass_done ? pass_last[2:0] : 3'd7;
    for (int j = 0; j < 8; j++) begin
      pass_mask[j] = (3'(j) >= mask_lo) && (3'(j) <= mask_hi);
    end
    set_flips = 4'($countones(pass_mask & ~map_rdata));
    clr_flips = 4'($countones(pass_mask & map_rdata));
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    act_next        = act;
    start_q_next    = start_q;
    len_q_next      = len_q;
    prod_next       = prod;
    nblk_next       = nblk;
    free_hint_next  = free_hint;
    used_count_next = used_count;
    scan_addr_next  = scan_addr;
    scan_off_next   = scan_off;
    scan_cnt_next   = scan_cnt;
    scan_start_next = scan_start;
    wrapped_next    = wrapped;
    pass_mode_next  = pass_mode;
    pass_addr_next  = pass_addr;
    pass_first_next = pass_first;
    pass_last_next  = pass_last;
    res_block_next  = res_block;
    res_status_next = res_status;
    res_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = pass_addr;
    mem_wdata       = map_rdata | pass_mask;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_BYTE) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          act_next     = action_t'(action);
          start_q_next = start_block;
          len_q_next   = length_bytes;
          state_next   = S_MUL;
        end
      end

      S_MUL: begin
        prod_next  = PRODW'(len_sum) * PRODW'(RECIP);
        state_next = S_LEN;
      end

      S_LEN: begin
        nblk_next  = NW'(prod >> DIV_SHIFT);
        state_next = S_DECODE;
      end

      S_DECODE: begin
        res_block_next  = start_q;
        res_status_next = ST_OK;
        if (act == ACT_ALLOC) begin
          if (too_long) begin
            res_status_next = ST_NOSPACE;
            state_next      = S_DONE;
          end else begin
            scan_addr_next = free_hint[3 +: AW];
            scan_off_next  = free_hint[2:0];
            scan_cnt_next  = '0;
            wrapped_next   = !wrap_enable;
            mem_re         = 1'b1;
            mem_raddr      = free_hint[3 +: AW];
            state_next     = S_SCAN;
          end
        end else if (!in_range) begin
          res_status_next = ST_RANGE;
          state_next      = S_DONE;
        end else begin
          if (act == ACT_FREE) begin
            free_hint_next = PW'(start_x);
          end
          if (nblk == '0) begin
            state_next = S_DONE;
          end else begin
            pass_first_next = PW'(start_x);
            pass_last_next  = PW'(run_end_x - XW'(1));
            pass_addr_next  = start_x[3 +: AW];
            mem_re          = 1'b1;
            mem_raddr       = start_x[3 +: AW];
            state_next      = S_PASS;
            unique case (act)
              ACT_FREE:   pass_mode_next = PM_CLEAR;
              ACT_MARK:   pass_mode_next = PM_SET;
              ACT_EXTEND: pass_mode_next = PM_CHECK;
              ACT_ALLOC:  pass_mode_next = PM_SET;
            endcase
          end
        end
      end

      S_SCAN: begin
        if (sc_hit) begin
          res_block_next = BLOCK_W'(sc_hit_start);
          free_hint_next = (hit_end_x >= NUM_X) ? '0 : PW'(hit_end_x);
          if (nblk == '0) begin
            state_next = S_DONE;
          end else begin
            pass_mode_next  = PM_SET;
            pass_first_next = sc_hit_start;
            pass_last_next  = PW'(hit_end_x - XW'(1));
            pass_addr_next  = sc_hit_start[3 +: AW];
            mem_re          = 1'b1;
            mem_raddr       = sc_hit_start[3 +: AW];
            state_next      = S_PASS;
          end
        end else if (!scan_last) begin
          scan_addr_next  = scan_addr + AW'(1);
          scan_off_next   = 3'd0;
          scan_cnt_next   = sc_cnt;
          scan_start_next = sc_start;
          mem_re          = 1'b1;
          mem_raddr       = scan_addr + AW'(1);
        end else if (!wrapped) begin
          scan_addr_next = '0;
          scan_off_next  = 3'd0;
          scan_cnt_next  = '0;
          wrapped_next   = 1'b1;
          mem_re         = 1'b1;
          mem_raddr      = '0;
        end else begin
          res_status_next = ST_NOSPACE;
          state_next      = S_DONE;
        end
      end

      S_PASS: begin
        unique case (pass_mode)
          PM_CHECK: begin
            if ((map_rdata & pass_mask) != 8'h00) begin
              res_status_next = ST_NOTFREE;
              state_next      = S_DONE;
            end else if (pass_done) begin
              pass_mode_next = PM_SET;
              pass_addr_next = pass_first[3 +: AW];
              mem_re         = 1'b1;
              mem_raddr      = pass_first[3 +: AW];
            end else begin
              pass_addr_next = pass_addr + AW'(1);
              mem_re         = 1'b1;
              mem_raddr      = pass_addr + AW'(1);
            end
          end
          PM_SET, PM_CLEAR: begin
            mem_we = 1'b1;
            if (pass_mode == PM_SET) begin
              mem_wdata       = map_rdata | pass_mask;
              used_count_next = used_count + CW'(set_flips);
            end else begin
              mem_wdata       = map_rdata & ~pass_mask;
              used_count_next = used_count - CW'(clr_flips);
            end
            if (pass_done) begin
              state_next = S_DONE;
            end else begin
              pass_addr_next = pass_addr + AW'(1);
              mem_re         = 1'b1;
              mem_raddr      = pass_addr + AW'(1);
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      free_hint  <= '0;
      used_count <= '0;
      wrapped    <= 1'b0;
      pass_mode  <= PM_CHECK;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      free_hint  <= free_hint_next;
      used_count <= used_count_next;
      wrapped    <= wrapped_next;
      pass_mode  <= pass_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    start_q    <= start_q_next;
    len_q      <= len_q_next;
    prod       <= prod_next;
    nblk       <= nblk_next;
    scan_addr  <= scan_addr_next;
    scan_off   <= scan_off_next;
    scan_cnt   <= scan_cnt_next;
    scan_start <= scan_start_next;
    pass_addr  <= pass_addr_next;
    pass_first <= pass_first_next;
    pass_last  <= pass_last_next;
    res_block  <= res_block_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_block <= res_block;
      status       <= res_status;
      used_blocks  <= USED_W'(used_count);
    end
  end

  `BBA_ASSERT_ALWAYS(a_used_in_store, used_count <= CW'(NUM_BLOCKS), "used count exceeds store")
  `BBA_ASSERT_ALWAYS(a_hint_in_store, free_hint < PW'(NUM_BLOCKS), "hint lies past the store")
  `BBA_ASSERT_IMPL(a_no_result_in_clear, state == S_CLEAR, !res_valid, "result during clearing")
  `BBA_ASSERT_IMPL(a_pass_in_run, state == S_PASS, pass_addr <= pass_last[3 +: AW], "pass overran")

endmodule
